### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, off during reset.
`define TBAS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression that must never be true outside reset.
`define TBAS_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

### rtl/tbas_pkg.sv
package tbas_pkg;

  localparam int QUEUE_DEPTH = 128;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int SUM_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic       OP_PUSH    = 1'b0;
  localparam logic       OP_TICK    = 1'b1;
  localparam logic [1:0] KIND_PRESS = 2'd0;
  localparam logic [1:0] KIND_DIR   = 2'd1;
  localparam logic [1:0] KIND_WAIT  = 2'd2;
  localparam logic [3:0] HAT_CENTER = 4'h8;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [SUM_W-1:0] cnt_t;

  typedef struct packed {
    logic        op;
    logic [1:0]  kind;
    logic [15:0] duration_ms;
    logic [13:0] press_mask;
    logic [1:0]  direction;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic [13:0] buttons;
    logic [3:0]  hat;
    logic        busy_res;
    logic [7:0]  pending;
  } result_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] duration;
    logic [13:0] payload;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
    cnt_t count;
  } queue_status_t;

  function automatic ptr_t ptr_inc(ptr_t p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + ptr_t'(1);
  endfunction

  function automatic logic [7:0] sat_pending(cnt_t v);
    return (32'(v) > 32'd255) ? 8'hFF : 8'(v);
  endfunction

endpackage

### rtl/tbas_queue.sv
`include "assert_macros.svh"

module tbas_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  tbas_pkg::entry_t         push_data,
  input  logic                     pop,
  output tbas_pkg::entry_t         head,
  output tbas_pkg::queue_status_t  status
);

  tbas_pkg::entry_t  store [tbas_pkg::QUEUE_DEPTH];
  tbas_pkg::ptr_t    rp;
  tbas_pkg::ptr_t    wp;
  tbas_pkg::ptr_t    rp_next;
  tbas_pkg::ptr_t    wp_next;
  logic              push_ok;

  always_comb begin
    status.empty = (rp == wp);
    status.full  = (tbas_pkg::ptr_inc(wp) == rp);
    if (wp >= rp) begin
      status.count = tbas_pkg::cnt_t'(wp) - tbas_pkg::cnt_t'(rp);
    end else begin
      status.count = tbas_pkg::cnt_t'(tbas_pkg::QUEUE_DEPTH) - tbas_pkg::cnt_t'(rp)
                   + tbas_pkg::cnt_t'(wp);
    end
    push_ok = push && !status.full;
    rp_next = (pop && !status.empty) ? tbas_pkg::ptr_inc(rp) : rp;
    wp_next = push_ok ? tbas_pkg::ptr_inc(wp) : wp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rp <= '0;
      wp <= '0;
    end else begin
      rp <= rp_next;
      wp <= wp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      store[wp] <= push_data;
    end
  end

  // head tracks the entry at the read pointer; forward a write into an empty queue
  always_ff @(posedge clk) begin
    if (push_ok && (wp == rp_next)) begin
      head <= push_data;
    end else begin
      head <= store[rp_next];
    end
  end

  `TBAS_NEVER(a_pop_empty, pop && status.empty, "pop from empty queue")
  `TBAS_ASSERT(a_full_holds, push && status.full |=> $stable(wp), "push stored while full")

endmodule

### rtl/timed_button_action_sequencer.sv
// Timed button action sequencer. An item (push or 1 ms tick) is taken on any cycle with
// start high; busy is always low, so one item is taken per cycle with no gaps. The result
// beat appears on result with done high in the cycle after the item is taken and is
// held for that single cycle only; the receiver cannot stall it and must sample it then.
// Queue holds QUEUE_DEPTH-1 actions in a single-port-write memory whose head entry is
// prefetched into a register, so a tick can pop it without waiting on a memory read.
`include "assert_macros.svh"

module timed_button_action_sequencer (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  tbas_pkg::item_t    item,
  output logic               busy,
  output logic               done,
  output tbas_pkg::result_t  result
);

  tbas_pkg::entry_t         head;
  tbas_pkg::queue_status_t  qs;
  tbas_pkg::entry_t         push_data;
  logic                     push;
  logic                     pop;
  logic                     push_ok;

  logic                     active;
  logic                     active_next;
  tbas_pkg::entry_t         cur;
  tbas_pkg::entry_t         cur_next;
  logic [15:0]              time_left;
  logic [15:0]              time_left_next;
  logic [13:0]              button_word;
  logic [13:0]              button_word_next;
  logic [3:0]               hat_code;
  logic [3:0]               hat_code_next;
  tbas_pkg::cnt_t           queued;
  tbas_pkg::result_t        result_next;

  assign busy = 1'b0;

  always_comb begin
    push_data.kind     = item.kind;
    push_data.duration = item.duration_ms;
    push_data.payload  = (item.kind == tbas_pkg::KIND_DIR) ? {12'b0, item.direction}
                                                            : item.press_mask;
    push    = start && (item.op == tbas_pkg::OP_PUSH);
    push_ok = push && !qs.full;
    pop     = 1'b0;

    active_next      = active;
    cur_next         = cur;
    time_left_next   = time_left;
    button_word_next = button_word;
    hat_code_next    = hat_code;

    if (start && (item.op == tbas_pkg::OP_TICK)) begin
      if (!active && !qs.empty) begin
        pop            = 1'b1;
        cur_next       = head;
        time_left_next = head.duration;
        active_next    = 1'b1;
        case (head.kind)
          tbas_pkg::KIND_PRESS: button_word_next = button_word | head.payload;
          tbas_pkg::KIND_DIR:   hat_code_next    = {1'b0, head.payload[1:0], 1'b0};
          default: ;
        endcase
      end else if (active && (time_left != 16'd0)) begin
        time_left_next = time_left - 16'd1;
      end
      if (active_next && (time_left_next == 16'd0)) begin
        active_next = 1'b0;
        case (cur_next.kind)
          tbas_pkg::KIND_PRESS: button_word_next = button_word_next & ~cur_next.payload;
          tbas_pkg::KIND_DIR:   hat_code_next    = tbas_pkg::HAT_CENTER;
          default: ;
        endcase
      end
    end

    queued = qs.count + tbas_pkg::cnt_t'(push_ok) - tbas_pkg::cnt_t'(pop);

    result_next.accepted = push_ok;
    result_next.buttons  = button_word_next;
    result_next.hat      = hat_code_next;
    result_next.busy_res = active_next;
    result_next.pending  = tbas_pkg::sat_pending(queued + tbas_pkg::cnt_t'(active_next));
  end

  tbas_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (qs)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      cur         <= '0;
      time_left   <= '0;
      button_word <= '0;
      hat_code    <= tbas_pkg::HAT_CENTER;
      done        <= 1'b0;
    end else begin
      active      <= active_next;
      cur         <= cur_next;
      time_left   <= time_left_next;
      button_word <= button_word_next;
      hat_code    <= hat_code_next;
      done        <= start;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  `TBAS_ASSERT(a_beat_follows, start |=> done, "result beat missing after item")
  `TBAS_ASSERT(a_idle_neutral, !active |-> (hat_code == tbas_pkg::HAT_CENTER) && (button_word == 14'd0), "idle runner left outputs held")

endmodule

### tb/timed_button_action_sequencer_test.sv
module timed_button_action_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam logic [1:0] DIR_UP     = 2'd0;
  localparam logic [1:0] DIR_RIGHT  = 2'd1;
  localparam logic [1:0] DIR_DOWN   = 2'd2;
  localparam logic [1:0] DIR_LEFT   = 2'd3;
  localparam logic [13:0] ALL_BUTTONS = 14'h3FFF;
  localparam int STALL_LIMIT = 500;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  tbas_pkg::item_t   item = '0;
  logic              busy;
  logic              done;
  tbas_pkg::result_t result;

  timed_button_action_sequencer dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mirror of the sequencer state
  tbas_pkg::entry_t slots [tbas_pkg::QUEUE_DEPTH];
  int unsigned      head = 0;
  int unsigned      tail = 0;
  logic             running = 1'b0;
  tbas_pkg::entry_t held = '0;
  logic [15:0]      hold_left = '0;
  logic [13:0]      btn_word = '0;
  logic [3:0]       hat_now = tbas_pkg::HAT_CENTER;

  tbas_pkg::result_t expected_reports [$];
  int      errors = 0;
  bit      allow_gaps = 1'b1;
  int      stall_cycles = 0;

  function automatic tbas_pkg::result_t predict_report(tbas_pkg::item_t it);
    tbas_pkg::result_t r;
    tbas_pkg::entry_t  a;
    int unsigned       queued;
    logic              popped;
    r = '0;
    popped = 1'b0;
    if (it.op == tbas_pkg::OP_PUSH) begin
      if ((tail + 1) % tbas_pkg::QUEUE_DEPTH != head) begin
        a.kind = it.kind;
        a.duration = it.duration_ms;
        a.payload = (it.kind == tbas_pkg::KIND_DIR) ? {12'd0, it.direction} : it.press_mask;
        slots[tail] = a;
        tail = (tail + 1) % tbas_pkg::QUEUE_DEPTH;
        r.accepted = 1'b1;
      end
    end else begin
      if (!running && head != tail) begin
        held = slots[head];
        head = (head + 1) % tbas_pkg::QUEUE_DEPTH;
        hold_left = held.duration;
        running = 1'b1;
        popped = 1'b1;
        if (held.kind == tbas_pkg::KIND_PRESS) begin
          btn_word = btn_word | held.payload;
        end else if (held.kind == tbas_pkg::KIND_DIR) begin
          hat_now = {1'b0, held.payload[1:0], 1'b0};
        end
      end
      if (running) begin
        if (!popped && hold_left != 0) begin
          hold_left = hold_left - 16'd1;
        end
        if (hold_left == 0) begin
          if (held.kind == tbas_pkg::KIND_PRESS) begin
            btn_word = btn_word & ~held.payload;
          end else if (held.kind == tbas_pkg::KIND_DIR) begin
            hat_now = tbas_pkg::HAT_CENTER;
          end
          running = 1'b0;
        end
      end
    end
    queued = (tail >= head) ? tail - head : tbas_pkg::QUEUE_DEPTH - head + tail;
    queued = queued + (running ? 1 : 0);
    r.buttons = btn_word;
    r.hat = hat_now;
    r.busy_res = running;
    r.pending = (queued > 255) ? 8'hFF : queued[7:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic check_report(tbas_pkg::result_t got);
    tbas_pkg::result_t want;
    if (expected_reports.size() == 0) begin
      report_mismatch("result beat with none expected", 32'(got), 0);
    end else begin
      want = expected_reports.pop_front();
      if (got.accepted !== want.accepted) begin
        report_mismatch("accepted", 32'(got.accepted), 32'(want.accepted));
      end
      if (got.buttons !== want.buttons) begin
        report_mismatch("buttons", 32'(got.buttons), 32'(want.buttons));
      end
      if (got.hat !== want.hat) begin
        report_mismatch("hat", 32'(got.hat), 32'(want.hat));
      end
      if (got.busy_res !== want.busy_res) begin
        report_mismatch("busy_res", 32'(got.busy_res), 32'(want.busy_res));
      end
      if (got.pending !== want.pending) begin
        report_mismatch("pending", 32'(got.pending), 32'(want.pending));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (done) check_report(result);
      if (start && !busy) expected_reports.push_back(predict_report(item));
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic idle_gap();
    int unsigned roll;
    int unsigned gap;
    if (!allow_gaps) return;
    roll = $urandom_range(0, 99);
    if (roll < 60) gap = 0;
    else if (roll < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_item(tbas_pkg::item_t it);
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    idle_gap();
  endtask

  task automatic push_action(logic [1:0] kind, logic [15:0] dur, logic [13:0] mask,
                             logic [1:0] dir);
    tbas_pkg::item_t it;
    it.op = tbas_pkg::OP_PUSH;
    it.kind = kind;
    it.duration_ms = dur;
    it.press_mask = mask;
    it.direction = dir;
    send_item(it);
  endtask

  // Action fields of a tick are don't-care; randomize them anyway
  task automatic tick();
    tbas_pkg::item_t it;
    it = tbas_pkg::item_t'(35'({$urandom, $urandom}));
    it.op = tbas_pkg::OP_TICK;
    send_item(it);
  endtask

  function automatic tbas_pkg::item_t random_push(int unsigned max_dur);
    tbas_pkg::item_t it;
    int unsigned     roll;
    it = tbas_pkg::item_t'(35'({$urandom, $urandom}));
    it.op = tbas_pkg::OP_PUSH;
    it.kind = ($urandom_range(0, 99) < 5) ? KIND_SPARE : 2'($urandom_range(0, 2));
    roll = $urandom_range(0, 99);
    if (roll < 70) it.duration_ms = 16'($urandom_range(0, 3));
    else if (roll < 96) it.duration_ms = 16'($urandom_range(4, 40));
    else it.duration_ms = 16'($urandom_range(41, 600));
    if (it.duration_ms > max_dur) it.duration_ms = 16'(max_dur);
    roll = $urandom_range(0, 19);
    if (roll == 0) it.press_mask = '0;
    else if (roll == 1) it.press_mask = ALL_BUTTONS;
    return it;
  endfunction

  task automatic test_empty_tick();
    tick();
    tick();
  endtask

  task automatic test_press_zero_hold();
    push_action(tbas_pkg::KIND_PRESS, 16'd0, ALL_BUTTONS, DIR_UP);
    tick();
    push_action(tbas_pkg::KIND_PRESS, 16'd2, 14'h0000, DIR_LEFT);
    repeat (3) tick();
  endtask

  task automatic test_directions();
    push_action(tbas_pkg::KIND_DIR, 16'd1, ALL_BUTTONS, DIR_UP);
    push_action(tbas_pkg::KIND_DIR, 16'd1, 14'h0000, DIR_RIGHT);
    push_action(tbas_pkg::KIND_DIR, 16'd0, 14'h1555, DIR_DOWN);
    push_action(tbas_pkg::KIND_DIR, 16'd2, 14'h2AAA, DIR_LEFT);
    repeat (8) tick();
  endtask

  task automatic test_wait_and_spare_kind();
    push_action(tbas_pkg::KIND_WAIT, 16'd2, ALL_BUTTONS, DIR_LEFT);
    push_action(KIND_SPARE, 16'd1, ALL_BUTTONS, DIR_RIGHT);
    repeat (6) tick();
  endtask

  // Long hold, then a direction that must wait for it
  task automatic test_longest_hold();
    allow_gaps = 1'b0;
    push_action(tbas_pkg::KIND_PRESS, 16'd300, ALL_BUTTONS, DIR_DOWN);
    push_action(tbas_pkg::KIND_DIR, 16'd0, 14'h0000, DIR_LEFT);
    repeat (305) tick();
    allow_gaps = 1'b1;
  endtask

  // Runner busy plus a full queue gives the largest pending count
  task automatic test_full_queue();
    push_action(tbas_pkg::KIND_DIR, 16'd3, 14'h0000, DIR_RIGHT);
    tick();
    repeat (tbas_pkg::QUEUE_DEPTH + 1) send_item(random_push(1));
    repeat (2 * tbas_pkg::QUEUE_DEPTH + 8) tick();
  endtask

  task automatic test_random_mix();
    int unsigned push_pct;
    for (int i = 0; i < 500; i++) begin
      if (i % 100 == 0) begin
        push_pct = $urandom_range(20, 80);
        allow_gaps = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 99) < push_pct) send_item(random_push(600));
      else tick();
    end
    allow_gaps = 1'b1;
  endtask

  initial begin
    int waited;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_tick();
    test_press_zero_hold();
    test_directions();
    test_wait_and_spare_kind();
    test_longest_hold();
    test_full_queue();
    test_random_mix();

    start <= 1'b0;
    waited = 0;
    while (expected_reports.size() != 0 && waited < 100) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (expected_reports.size() != 0) begin
      report_mismatch("results never produced", 0, expected_reports.size());
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
